// ===== rtl/rmq_pkg.sv =====
// Shared types, widths and constants for the rotation matrix to quaternion block.
// No dependencies; every other file imports this package.
package rmq_pkg;

  localparam int DW     = 16;
  localparam int FRAC   = 14;
  localparam int MAXW   = (DW > FRAC) ? DW : FRAC;
  // Signed square-root argument and its clamped positive form
  localparam int ARG_W  = MAXW + 3;
  localparam int CARG_W = MAXW + 2;
  // First square root: radicand is arg * ONE
  localparam int RAD_W  = CARG_W + FRAC;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int S_W    = ROOT_W + 1;
  // Numerators are sums or differences of two elements
  localparam int NUM_W  = DW + 1;
  localparam int MAG_W  = DW + 1;
  // Unnormalized parts: quotient bits of num * ONE / s, or the diagonal part
  localparam int PDIV_W = DW + FRAC - FRAC / 2 + 1;
  localparam int PART_W = (PDIV_W > ROOT_W) ? PDIV_W : ROOT_W;
  localparam int PMAX_W = 31;
  // Norm
  localparam int SUM_W  = 2 * PART_W + 2;
  localparam int NRM_W  = (SUM_W + 1) / 2;
  // Output quotient never exceeds ONE
  localparam int OQ_W   = FRAC + 1;
  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int PTR_W  = 2;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  typedef struct packed {
    logic signed [DW-1:0] r00;
    logic signed [DW-1:0] r01;
    logic signed [DW-1:0] r02;
    logic signed [DW-1:0] r10;
    logic signed [DW-1:0] r11;
    logic signed [DW-1:0] r12;
    logic signed [DW-1:0] r20;
    logic signed [DW-1:0] r21;
    logic signed [DW-1:0] r22;
  } rmq_in_t;

  typedef struct packed {
    logic signed [DW-1:0] quat_w;
    logic signed [DW-1:0] quat_x;
    logic signed [DW-1:0] quat_y;
    logic signed [DW-1:0] quat_z;
    logic [1:0]           branch_used;
    logic                 clamped;
  } rmq_out_t;

  // Classified item: branch, clamped argument, numerators as sign and magnitude
  typedef struct packed {
    branch_t                 branch;
    logic                    clamped;
    logic [CARG_W-1:0]       carg;
    logic [3:0]              neg;
    logic [3:0][MAG_W-1:0]   mag;
  } rmq_cls_t;

  // Unnormalized quaternion parts, sign and magnitude
  typedef struct packed {
    branch_t                 branch;
    logic                    clamped;
    logic [3:0]              neg;
    logic [3:0][PART_W-1:0]  mag;
  } rmq_part_t;

  typedef struct packed {
    logic [PTR_W:0] count;
    logic           full;
  } rmq_qstat_t;

endpackage

// ===== rtl/rmq_front.sv =====
// Front end: classifies a matrix into its branch, forms the clamped root argument
// and the four numerators. Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  rmq_in_t  item,
  output logic     cls_vld,
  output rmq_cls_t cls
);

  localparam logic signed [ARG_W-1:0] ONE_A =
    {{(ARG_W-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};

  logic signed [ARG_W-1:0] a00, a11, a22, tr, arg;
  logic signed [NUM_W-1:0] da, db, dc, sa, sb, sc;
  logic signed [NUM_W-1:0] num [4];
  rmq_cls_t cls_nxt, cls_r;
  logic     vld_r;

  always_comb begin
    a00 = ARG_W'(item.r00);
    a11 = ARG_W'(item.r11);
    a22 = ARG_W'(item.r22);
    tr  = a00 + a11 + a22;
    da  = NUM_W'(item.r21) - NUM_W'(item.r12);
    db  = NUM_W'(item.r02) - NUM_W'(item.r20);
    dc  = NUM_W'(item.r10) - NUM_W'(item.r01);
    sa  = NUM_W'(item.r01) + NUM_W'(item.r10);
    sb  = NUM_W'(item.r02) + NUM_W'(item.r20);
    sc  = NUM_W'(item.r12) + NUM_W'(item.r21);
    cls_nxt = '0;
    if (tr > 0) begin
      cls_nxt.branch = BR_TRACE;
      arg = ONE_A + tr;
      num[0] = '0; num[1] = da; num[2] = db; num[3] = dc;
    end else if (a00 > a11 && a00 > a22) begin
      cls_nxt.branch = BR_X;
      arg = ONE_A + a00 - a11 - a22;
      num[0] = da; num[1] = '0; num[2] = sa; num[3] = sb;
    end else if (a11 > a22) begin
      cls_nxt.branch = BR_Y;
      arg = ONE_A + a11 - a00 - a22;
      num[0] = db; num[1] = sa; num[2] = '0; num[3] = sc;
    end else begin
      cls_nxt.branch = BR_Z;
      arg = ONE_A + a22 - a00 - a11;
      num[0] = dc; num[1] = sb; num[2] = sc; num[3] = '0;
    end
    // clamp a nonpositive argument to one LSB
    if (arg <= 0) begin
      cls_nxt.clamped = 1'b1;
      cls_nxt.carg    = CARG_W'(1);
    end else begin
      cls_nxt.clamped = 1'b0;
      cls_nxt.carg    = CARG_W'(arg);
    end
    for (int k = 0; k < 4; k++) begin
      cls_nxt.neg[k] = num[k][NUM_W-1];
      cls_nxt.mag[k] = num[k][NUM_W-1] ? MAG_W'(-num[k]) : MAG_W'(num[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    cls_r <= cls_nxt;
  end

  assign cls_vld = vld_r;
  assign cls     = cls_r;

endmodule

// ===== rtl/rmq_fifo.sv =====
// Short queue between the front end and the arithmetic back end.
// Depends on rmq_pkg.
module rmq_fifo import rmq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rmq_cls_t   push_data,
  output logic       pop,
  output rmq_cls_t   pop_data,
  output rmq_qstat_t stat
);

  rmq_cls_t         mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             rd_en;
  logic             pop_r;
  rmq_cls_t         pop_data_r;

  // back end never stalls: drain one beat whenever anything is queued
  assign rd_en    = (count_r != '0);
  assign pop      = pop_r;
  assign pop_data = pop_data_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      pop_r    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
      pop_r   <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
    if (rd_en) begin
      pop_data_r <= mem_r[rd_ptr_r];
    end
  end

  assign stat.count = count_r;
  assign stat.full  = (count_r == (PTR_W+1)'(QDEPTH));

endmodule

// ===== rtl/rmq_part.sv =====
// Back end, first half: pipelined square root of the argument, then four pipelined
// dividers by s = 2*root, giving the unnormalized parts. Depends on rmq_pkg.
module rmq_part import rmq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  input  rmq_cls_t  in_cls,
  output logic      out_vld,
  output rmq_part_t out_part
);

  localparam int X1_W   = 2 * ROOT_W;
  localparam int WIDE_W = PART_W + S_W + 1;

  typedef struct packed {
    rmq_cls_t            cls;
    logic [X1_W-1:0]     x;
    logic [ROOT_W+1:0]   rem;
    logic [ROOT_W-1:0]   q;
  } sq1_t;

  typedef struct packed {
    branch_t                branch;
    logic                   clamped;
    logic [3:0]             neg;
    logic [ROOT_W-1:0]      diag;
    logic [S_W-1:0]         s;
    logic [3:0][S_W:0]      rem;
    logic [3:0][PART_W-1:0] x;
    logic [3:0][PART_W-1:0] q;
  } dv1_t;

  function automatic sq1_t sq1_step(input sq1_t a);
    sq1_t b;
    logic [ROOT_W+3:0] t, trial;
    b     = a;
    t     = {a.rem, a.x[X1_W-1 -: 2]};
    trial = {2'b00, a.q, 2'b01};
    b.x   = {a.x[X1_W-3:0], 2'b00};
    if (t >= trial) begin
      b.rem = (ROOT_W+2)'(t - trial);
      b.q   = {a.q[ROOT_W-2:0], 1'b1};
    end else begin
      b.rem = (ROOT_W+2)'(t);
      b.q   = {a.q[ROOT_W-2:0], 1'b0};
    end
    return b;
  endfunction

  function automatic dv1_t dv1_prep(input sq1_t a);
    dv1_t b;
    logic [ROOT_W:0]   rp1;
    logic [WIDE_W-1:0] wide;
    b.branch  = a.cls.branch;
    b.clamped = a.cls.clamped;
    b.neg     = a.cls.neg;
    rp1       = {1'b0, a.q} + 1'b1;
    b.diag    = rp1[ROOT_W:1];
    b.s       = {a.q, 1'b0};
    for (int k = 0; k < 4; k++) begin
      // dividend = mag * ONE + s/2 for round half away from zero
      wide     = (WIDE_W'(a.cls.mag[k]) << FRAC) + WIDE_W'(b.s >> 1);
      b.rem[k] = wide[WIDE_W-1 -: S_W+1];
      b.x[k]   = wide[PART_W-1:0];
      b.q[k]   = '0;
    end
    return b;
  endfunction

  function automatic dv1_t dv1_step(input dv1_t a);
    dv1_t b;
    logic [S_W:0] t;
    b = a;
    for (int k = 0; k < 4; k++) begin
      t        = {a.rem[k][S_W-1:0], a.x[k][PART_W-1]};
      b.x[k]   = {a.x[k][PART_W-2:0], 1'b0};
      if (t >= {1'b0, a.s}) begin
        b.rem[k] = t - {1'b0, a.s};
        b.q[k]   = {a.q[k][PART_W-2:0], 1'b1};
      end else begin
        b.rem[k] = t;
        b.q[k]   = {a.q[k][PART_W-2:0], 1'b0};
      end
    end
    return b;
  endfunction

  function automatic rmq_part_t part_final(input dv1_t a);
    rmq_part_t b;
    logic [PART_W-1:0] q;
    b.branch  = a.branch;
    b.clamped = a.clamped;
    for (int k = 0; k < 4; k++) begin
      q = a.q[k];
      if (PART_W > PMAX_W && (q >> PMAX_W) != '0) begin
        q = PART_W'({PMAX_W{1'b1}});
      end
      if (a.branch == branch_t'(k)) begin
        b.mag[k] = PART_W'(a.diag);
        b.neg[k] = 1'b0;
      end else begin
        b.mag[k] = q;
        b.neg[k] = a.neg[k];
      end
    end
    return b;
  endfunction

  sq1_t              s1_r   [ROOT_W+1];
  sq1_t              s1_nxt [ROOT_W+1];
  logic [ROOT_W:0]   s1_vld_r;
  dv1_t              d1_r   [PART_W+1];
  dv1_t              d1_nxt [PART_W+1];
  logic [PART_W:0]   d1_vld_r;
  rmq_part_t         out_r;
  logic              out_vld_r;

  always_comb begin
    s1_nxt[0].cls = in_cls;
    s1_nxt[0].x   = {{(X1_W-CARG_W){1'b0}}, in_cls.carg} << FRAC;
    s1_nxt[0].rem = '0;
    s1_nxt[0].q   = '0;
    for (int i = 0; i < ROOT_W; i++) begin
      s1_nxt[i+1] = sq1_step(s1_r[i]);
    end
    d1_nxt[0] = dv1_prep(s1_r[ROOT_W]);
    for (int i = 0; i < PART_W; i++) begin
      d1_nxt[i+1] = dv1_step(d1_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= '0;
      d1_vld_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= {s1_vld_r[ROOT_W-1:0], in_vld};
      d1_vld_r  <= {d1_vld_r[PART_W-1:0], s1_vld_r[ROOT_W]};
      out_vld_r <= d1_vld_r[PART_W];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= ROOT_W; i++) begin
      s1_r[i] <= s1_nxt[i];
    end
    for (int i = 0; i <= PART_W; i++) begin
      d1_r[i] <= d1_nxt[i];
    end
    out_r <= part_final(d1_r[PART_W]);
  end

  assign out_vld  = out_vld_r;
  assign out_part = out_r;

endmodule

// ===== rtl/rmq_norm.sv =====
// Back end, second half: sum of squares, pipelined norm square root and four
// pipelined dividers by the norm, with output rounding and saturation. Depends on rmq_pkg.
module rmq_norm import rmq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  input  rmq_part_t in_part,
  output logic      out_vld,
  output rmq_out_t  out_item
);

  localparam int X2_W    = 2 * NRM_W;
  localparam int WIDE2_W = OQ_W + NRM_W + 1;
  localparam int SQ_W    = 2 * PART_W;
  localparam int CMP_W   = (OQ_W > DW) ? OQ_W : DW;
  localparam logic [DW-1:0] OMAX = {1'b0, {(DW-1){1'b1}}};

  typedef struct packed {
    rmq_part_t            p;
    logic [3:0][SQ_W-1:0] sq;
  } sqr_t;

  typedef struct packed {
    rmq_part_t            p;
    logic [1:0][SQ_W:0]   pair;
  } pr_t;

  typedef struct packed {
    rmq_part_t            p;
    logic [X2_W-1:0]      x;
    logic [NRM_W+1:0]     rem;
    logic [NRM_W-1:0]     q;
  } sq2_t;

  typedef struct packed {
    branch_t               branch;
    logic                  clamped;
    logic [3:0]            neg;
    logic [NRM_W-1:0]      n;
    logic [3:0][NRM_W:0]   rem;
    logic [3:0][OQ_W-1:0]  x;
    logic [3:0][OQ_W-1:0]  q;
  } dv2_t;

  function automatic sq2_t sq2_step(input sq2_t a);
    sq2_t b;
    logic [NRM_W+3:0] t, trial;
    b     = a;
    t     = {a.rem, a.x[X2_W-1 -: 2]};
    trial = {2'b00, a.q, 2'b01};
    b.x   = {a.x[X2_W-3:0], 2'b00};
    if (t >= trial) begin
      b.rem = (NRM_W+2)'(t - trial);
      b.q   = {a.q[NRM_W-2:0], 1'b1};
    end else begin
      b.rem = (NRM_W+2)'(t);
      b.q   = {a.q[NRM_W-2:0], 1'b0};
    end
    return b;
  endfunction

  function automatic dv2_t dv2_prep(input sq2_t a);
    dv2_t b;
    logic [WIDE2_W-1:0] wide;
    b.branch  = a.p.branch;
    b.clamped = a.p.clamped;
    b.neg     = a.p.neg;
    b.n       = (a.q == '0) ? NRM_W'(1) : a.q;
    for (int k = 0; k < 4; k++) begin
      wide     = (WIDE2_W'(a.p.mag[k]) << FRAC) + WIDE2_W'(b.n >> 1);
      b.rem[k] = wide[WIDE2_W-1 -: NRM_W+1];
      b.x[k]   = wide[OQ_W-1:0];
      b.q[k]   = '0;
    end
    return b;
  endfunction

  function automatic dv2_t dv2_step(input dv2_t a);
    dv2_t b;
    logic [NRM_W:0] t;
    b = a;
    for (int k = 0; k < 4; k++) begin
      t      = {a.rem[k][NRM_W-1:0], a.x[k][OQ_W-1]};
      b.x[k] = {a.x[k][OQ_W-2:0], 1'b0};
      if (t >= {1'b0, a.n}) begin
        b.rem[k] = t - {1'b0, a.n};
        b.q[k]   = {a.q[k][OQ_W-2:0], 1'b1};
      end else begin
        b.rem[k] = t;
        b.q[k]   = {a.q[k][OQ_W-2:0], 1'b0};
      end
    end
    return b;
  endfunction

  function automatic logic [DW-1:0] out_part(input logic [OQ_W-1:0] q, input logic neg);
    logic [DW-1:0] m;
    if (CMP_W'(q) > CMP_W'(OMAX)) begin
      m = OMAX;
    end else begin
      m = DW'(q);
    end
    return neg ? -m : m;
  endfunction

  sqr_t            sq_r;
  pr_t             pr_r;
  sq2_t            s2_r   [NRM_W+1];
  sq2_t            s2_nxt [NRM_W+1];
  logic [NRM_W:0]  s2_vld_r;
  dv2_t            d2_r   [OQ_W+1];
  dv2_t            d2_nxt [OQ_W+1];
  logic [OQ_W:0]   d2_vld_r;
  logic [1:0]      acc_vld_r;
  rmq_out_t        out_r;
  logic            out_vld_r;

  always_comb begin
    s2_nxt[0].p   = pr_r.p;
    s2_nxt[0].x   = X2_W'(SUM_W'(pr_r.pair[0]) + SUM_W'(pr_r.pair[1]));
    s2_nxt[0].rem = '0;
    s2_nxt[0].q   = '0;
    for (int i = 0; i < NRM_W; i++) begin
      s2_nxt[i+1] = sq2_step(s2_r[i]);
    end
    d2_nxt[0] = dv2_prep(s2_r[NRM_W]);
    for (int i = 0; i < OQ_W; i++) begin
      d2_nxt[i+1] = dv2_step(d2_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
      s2_vld_r  <= '0;
      d2_vld_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      acc_vld_r <= {acc_vld_r[0], in_vld};
      s2_vld_r  <= {s2_vld_r[NRM_W-1:0], acc_vld_r[1]};
      d2_vld_r  <= {d2_vld_r[OQ_W-1:0], s2_vld_r[NRM_W]};
      out_vld_r <= d2_vld_r[OQ_W];
    end
  end

  always_ff @(posedge clk) begin
    sq_r.p <= in_part;
    for (int k = 0; k < 4; k++) begin
      sq_r.sq[k] <= in_part.mag[k] * in_part.mag[k];
    end
    pr_r.p       <= sq_r.p;
    pr_r.pair[0] <= (SQ_W+1)'(sq_r.sq[0]) + (SQ_W+1)'(sq_r.sq[1]);
    pr_r.pair[1] <= (SQ_W+1)'(sq_r.sq[2]) + (SQ_W+1)'(sq_r.sq[3]);
    for (int i = 0; i <= NRM_W; i++) begin
      s2_r[i] <= s2_nxt[i];
    end
    for (int i = 0; i <= OQ_W; i++) begin
      d2_r[i] <= d2_nxt[i];
    end
    out_r.quat_w      <= out_part(d2_r[OQ_W].q[0], d2_r[OQ_W].neg[0]);
    out_r.quat_x      <= out_part(d2_r[OQ_W].q[1], d2_r[OQ_W].neg[1]);
    out_r.quat_y      <= out_part(d2_r[OQ_W].q[2], d2_r[OQ_W].neg[2]);
    out_r.quat_z      <= out_part(d2_r[OQ_W].q[3], d2_r[OQ_W].neg[3]);
    out_r.branch_used <= d2_r[OQ_W].branch;
    out_r.clamped     <= d2_r[OQ_W].clamped;
  end

  assign out_vld  = out_vld_r;
  assign out_item = out_r;

endmodule

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
// Top level of the rotation matrix to quaternion converter (largest-diagonal method).
// Depends on rmq_pkg, rmq_front, rmq_fifo, rmq_part and rmq_norm.
//
// Takes one 3x3 matrix beat per clock (start high while busy is low) and
// returns the unit quaternion in Q2.14, the branch used and the clamp flag as a
// single out_strobe beat, in order. The receiver cannot hold results off, so
// every stage after the queue advances each cycle. Rate is one matrix per
// clock, sustained. From the accepting edge to out_strobe a beat passes the
// front register, the queue write and the registered queue read, then the
// first bit-per-stage square root and divider bank, the squares and pair sums,
// and the second bit-per-stage square root and divider bank. The queue drains
// one beat every cycle, so it never holds more than one beat and busy stays
// low.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rmq_in_t  in_item,
  output logic     out_strobe,
  output rmq_out_t out_item
);

  logic       accept;
  logic       cls_vld;
  rmq_cls_t   cls;
  logic       q_pop;
  rmq_cls_t   q_data;
  rmq_qstat_t q_stat;
  logic       part_vld;
  rmq_part_t  part;

  // keep room for the beat held in the front register
  assign busy   = (q_stat.count >= (PTR_W+1)'(QDEPTH-2));
  assign accept = start && !busy;

  // classify and form the root argument
  rmq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (in_item),
    .cls_vld (cls_vld),
    .cls     (cls)
  );

  // decouple front from back
  rmq_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cls_vld),
    .push_data (cls),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  // root and divide by s
  rmq_part u_part (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (q_pop),
    .in_cls   (q_data),
    .out_vld  (part_vld),
    .out_part (part)
  );

  // normalize and saturate
  rmq_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (part_vld),
    .in_part  (part),
    .out_vld  (out_strobe),
    .out_item (out_item)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(cls_vld && q_stat.full))
    else $error("queue push while full");

  a_trace_not_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.clamped) |-> (out_item.branch_used != BR_TRACE))
    else $error("clamp flagged on trace branch");

  a_trace_w_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.branch_used == BR_TRACE) |-> !out_item.quat_w[DW-1])
    else $error("negative scalar part on trace branch");
`endif

endmodule
